### rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and opcodes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_W         = 34;
    localparam int DEN_OUT_W         = 32;
    localparam int OP_W              = 4;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_ADD = 4'd0;
    localparam op_t OP_SUB = 4'd1;
    localparam op_t OP_MUL = 4'd2;
    localparam op_t OP_DIV = 4'd3;
    localparam op_t OP_EQ  = 4'd4;
    localparam op_t OP_GT  = 4'd5;
    localparam op_t OP_LT  = 4'd6;
    localparam op_t OP_GE  = 4'd7;
    localparam op_t OP_LE  = 4'd8;

endpackage

### rtl/core/rau_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_addsub
// Shared adder/subtractor with carry out (carry = no borrow on subtract).
// ----------------------------------------------------------------------------
module rau_addsub #(
    parameter int WIDTH = 34
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);

    logic [WIDTH-1:0] b_inv;
    logic [WIDTH:0]   total;

    assign b_inv = b ^ {WIDTH{sub}};
    assign total = {1'b0, a} + {1'b0, b_inv} + (WIDTH+1)'(sub);
    assign sum   = total[WIDTH-1:0];
    assign carry = total[WIDTH];

endmodule

### rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Signed fraction add/sub/mul/div with gcd reduction, plus five comparisons.
// ----------------------------------------------------------------------------
// One word in, one word out. The block works on one word at a time: in_stall
// is high from the cycle after a word is taken until its result is moved to
// the output register, and a finished result may wait there under out_stall
// while the next word is already taken. Steps per word at OPERAND_WIDTH = W,
// with S = min(2W+1, 64) the internal magnitude width: the four cross products
// on the single W x W multiplier (one product per cycle), a combine step, then
// for arithmetic ops absolute value of numerator and denominator, the binary
// gcd (one halve, subtract or swap step per cycle plus a closing step; the
// step count depends on the values), two restoring divisions of S quotient
// bits plus a sign step each, and the output load. Comparisons go from the
// combine step straight to the output load, and unused opcodes go there
// straight from acceptance. Every add, subtract, compare and negate after the
// multiplier goes through one shared S+1 bit adder/subtractor. The result
// sign follows the operand signs as they come out of the cross products: a
// negative denominator stays negative. Both parts zero gives div_zero = 1 and
// 0/0.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [OP_W-1:0]                 op,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [NUM_OUT_W-1:0]     res_num,
    output logic signed [DEN_OUT_W-1:0]     res_den,
    output logic                            cmp_true,
    output logic                            div_zero
);

    // Widths: PW product, SW signed sum / magnitude, UW shared unit.
    localparam int PW  = 2 * OPERAND_WIDTH;
    localparam int SW  = (PW + 1 > 64) ? 64 : PW + 1;
    localparam int UW  = SW + 1;
    localparam int CW  = $clog2(SW + 1);
    localparam int XNW = (SW > NUM_OUT_W) ? SW : NUM_OUT_W;
    localparam int XDW = (SW > DEN_OUT_W) ? SW : DEN_OUT_W;

    // Multiplier schedule: one cross product per cycle.
    localparam logic [1:0] MS_ANBD = 2'd0;
    localparam logic [1:0] MS_ADBN = 2'd1;
    localparam logic [1:0] MS_ADBD = 2'd2;
    localparam logic [1:0] MS_ANBN = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_ABS_N,
        S_ABS_D,
        S_GCD,
        S_DIV,
        S_NEG,
        S_DONE
    } state_t;

    state_t state_reg;

    // Operand and product registers
    op_t                      op_reg;
    logic signed [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [1:0]               step_reg;
    logic signed [PW-1:0]     p_anbd_reg, p_adbn_reg, p_adbd_reg, p_anbn_reg;

    // Reduction datapath
    logic [SW-1:0]            mn_reg, md_reg;     // num/den, then magnitudes
    logic                     sgn_n_reg, sgn_d_reg;
    logic [SW-1:0]            x_reg, y_reg;       // gcd operands
    logic [CW-1:0]            k_reg;              // common power of two
    logic [SW-1:0]            g_reg;
    logic [SW-1:0]            quo_reg, rem_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     sel_reg;            // 0: numerator, 1: denominator

    // Result staging and output registers
    logic [SW-1:0]            rn_reg, rd_reg;
    logic                     cmp_reg, dz_reg;
    logic                     out_valid_reg;
    logic [NUM_OUT_W-1:0]     res_num_reg;
    logic [DEN_OUT_W-1:0]     res_den_reg;
    logic                     cmp_true_reg, div_zero_reg;

    // Multiplier
    logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic signed [PW-1:0]     mul_p;

    // Shared add/sub unit
    logic [UW-1:0]            u_a, u_b, u_sum;
    logic                     u_sub, u_carry;

    // Misc combinational
    logic                     cmp_eq, cmp_lt, cmp_res;
    logic [SW-1:0]            gcd_mag, gcd_val, neg_val;
    logic signed [XNW-1:0]    num_ext;
    logic signed [XDW-1:0]    den_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign cmp_true  = cmp_true_reg;
    assign div_zero  = div_zero_reg;

    always_comb
    begin
        case (step_reg)
            MS_ANBD: begin mul_a = an_reg; mul_b = bd_reg; end
            MS_ADBN: begin mul_a = ad_reg; mul_b = bn_reg; end
            MS_ADBD: begin mul_a = ad_reg; mul_b = bd_reg; end
            default: begin mul_a = an_reg; mul_b = bn_reg; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b1;
        unique case (state_reg)
            S_COMB:
            begin
                u_a   = UW'(p_anbd_reg);
                u_b   = UW'(p_adbn_reg);
                u_sub = (op_reg != OP_ADD);
            end
            S_ABS_N: u_b = {1'b0, mn_reg};
            S_ABS_D: u_b = {1'b0, md_reg};
            S_GCD:
            begin
                u_a = {1'b0, x_reg};
                u_b = {1'b0, y_reg};
            end
            S_DIV:
            begin
                u_a = {rem_reg, quo_reg[SW-1]};
                u_b = {1'b0, g_reg};
            end
            S_NEG: u_b = {1'b0, quo_reg};
            default: u_b = '0;
        endcase
    end

    rau_addsub #(
        .WIDTH (UW)
    ) u_addsub (
        .a     (u_a),
        .b     (u_b),
        .sub   (u_sub),
        .sum   (u_sum),
        .carry (u_carry)
    );

    // Comparison from lhs - rhs, exact in UW bits
    assign cmp_eq = (u_sum == '0);
    assign cmp_lt = u_sum[UW-1];

    always_comb
    begin
        case (op_reg)
            OP_EQ:   cmp_res = cmp_eq;
            OP_GT:   cmp_res = !cmp_lt && !cmp_eq;
            OP_LT:   cmp_res = cmp_lt;
            OP_GE:   cmp_res = !cmp_lt;
            default: cmp_res = cmp_lt || cmp_eq;
        endcase
    end

    assign gcd_mag = (x_reg == '0) ? y_reg : x_reg;
    assign gcd_val = gcd_mag << k_reg;
    assign neg_val = (sel_reg ? sgn_d_reg : sgn_n_reg) ? u_sum[SW-1:0] : quo_reg;
    assign num_ext = XNW'($signed(rn_reg));
    assign den_ext = XDW'($signed(rd_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ADD;
            an_reg        <= '0;
            ad_reg        <= '0;
            bn_reg        <= '0;
            bd_reg        <= '0;
            step_reg      <= MS_ANBD;
            p_anbd_reg    <= '0;
            p_adbn_reg    <= '0;
            p_adbd_reg    <= '0;
            p_anbn_reg    <= '0;
            mn_reg        <= '0;
            md_reg        <= '0;
            sgn_n_reg     <= 1'b0;
            sgn_d_reg     <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            k_reg         <= '0;
            g_reg         <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            rn_reg        <= '0;
            rd_reg        <= '0;
            cmp_reg       <= 1'b0;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            res_num_reg   <= '0;
            res_den_reg   <= '0;
            cmp_true_reg  <= 1'b0;
            div_zero_reg  <= 1'b0;
        end
        else
        begin
            // in S_DONE the output load below owns out_valid_reg
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg   <= op;
                        an_reg   <= a_num;
                        ad_reg   <= a_den;
                        bn_reg   <= b_num;
                        bd_reg   <= b_den;
                        step_reg <= MS_ANBD;
                        rn_reg   <= '0;
                        rd_reg   <= '0;
                        cmp_reg  <= 1'b0;
                        dz_reg   <= 1'b0;
                        // unused opcodes return all zero
                        state_reg <= (op > OP_LE) ? S_DONE : S_MUL;
                    end
                end

                S_MUL:
                begin
                    case (step_reg)
                        MS_ANBD: p_anbd_reg <= mul_p;
                        MS_ADBN: p_adbn_reg <= mul_p;
                        MS_ADBD: p_adbd_reg <= mul_p;
                        default: p_anbn_reg <= mul_p;
                    endcase
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == MS_ANBN)
                    begin
                        state_reg <= S_COMB;
                    end
                end

                S_COMB:
                begin
                    state_reg <= S_ABS_N;
                    case (op_reg) inside
                        OP_ADD, OP_SUB:
                        begin
                            mn_reg <= u_sum[SW-1:0];   // wraps at SW bits
                            md_reg <= SW'(p_adbd_reg);
                        end
                        OP_MUL:
                        begin
                            mn_reg <= SW'(p_anbn_reg);
                            md_reg <= SW'(p_adbd_reg);
                        end
                        OP_DIV:
                        begin
                            mn_reg <= SW'(p_anbd_reg);
                            md_reg <= SW'(p_adbn_reg);
                        end
                        default:
                        begin
                            cmp_reg   <= cmp_res;
                            state_reg <= S_DONE;
                        end
                    endcase
                end

                S_ABS_N:
                begin
                    sgn_n_reg <= mn_reg[SW-1];
                    if (mn_reg[SW-1])
                    begin
                        mn_reg <= u_sum[SW-1:0];
                    end
                    state_reg <= S_ABS_D;
                end

                S_ABS_D:
                begin
                    sgn_d_reg <= md_reg[SW-1];
                    if (md_reg[SW-1])
                    begin
                        md_reg <= u_sum[SW-1:0];
                        y_reg  <= u_sum[SW-1:0];
                    end
                    else
                    begin
                        y_reg <= md_reg;
                    end
                    x_reg     <= mn_reg;
                    k_reg     <= '0;
                    state_reg <= S_GCD;
                end

                // binary gcd, one step per cycle
                S_GCD:
                begin
                    if (x_reg == '0 || y_reg == '0)
                    begin
                        if (gcd_val == '0)
                        begin
                            dz_reg    <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            g_reg     <= gcd_val;
                            quo_reg   <= mn_reg;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            sel_reg   <= 1'b0;
                            state_reg <= S_DIV;
                        end
                    end
                    else if (!x_reg[0] && !y_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + CW'(1);
                    end
                    else if (!x_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                    end
                    else if (!y_reg[0])
                    begin
                        y_reg <= y_reg >> 1;
                    end
                    else if (u_carry)
                    begin
                        x_reg <= u_sum[SW-1:0];      // x >= y
                    end
                    else
                    begin
                        x_reg <= y_reg;
                        y_reg <= x_reg;
                    end
                end

                // restoring division, one quotient bit per cycle
                S_DIV:
                begin
                    if (u_carry)
                    begin
                        rem_reg <= u_sum[SW-1:0];
                    end
                    else
                    begin
                        rem_reg <= u_a[SW-1:0];
                    end
                    quo_reg <= {quo_reg[SW-2:0], u_carry};
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(SW - 1))
                    begin
                        state_reg <= S_NEG;
                    end
                end

                S_NEG:
                begin
                    if (!sel_reg)
                    begin
                        rn_reg    <= neg_val;
                        quo_reg   <= md_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        sel_reg   <= 1'b1;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        rd_reg    <= neg_val;
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        res_num_reg   <= num_ext[NUM_OUT_W-1:0];
                        res_den_reg   <= den_ext[DEN_OUT_W-1:0];
                        cmp_true_reg  <= cmp_reg;
                        div_zero_reg  <= dz_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/rau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_port_checks
// Port-level checks for the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_port_checks
    import rau_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [NUM_OUT_W-1:0] res_num,
    input logic [DEN_OUT_W-1:0] res_den,
    input logic                 cmp_true,
    input logic                 div_zero
);

    // one word in flight: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a word is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den)
            && $stable(cmp_true) && $stable(div_zero))
        else $error("stalled result word changed");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> res_num == '0 && res_den == '0 && !cmp_true)
        else $error("div_zero word not 0/0");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmp_true |-> res_num == '0 && res_den == '0 && !div_zero)
        else $error("comparison word carries a fraction");

endmodule

bind rational_arithmetic_unit rau_port_checks u_rau_port_checks (.*);

### verif/rau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// Watches both channels of the rational arithmetic unit, predicts each result
// word from the accepted input word and compares it with what comes out.
// ----------------------------------------------------------------------------
module rau_checker
    import rau_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [OP_W-1:0]             op,
    input  logic signed [W-1:0]         a_num,
    input  logic signed [W-1:0]         a_den,
    input  logic signed [W-1:0]         b_num,
    input  logic signed [W-1:0]         b_den,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [NUM_OUT_W-1:0] res_num,
    input  logic signed [DEN_OUT_W-1:0] res_den,
    input  logic                        cmp_true,
    input  logic                        div_zero,
    output int                          mismatches,
    output int                          outstanding
);

    typedef struct packed {
        logic signed [NUM_OUT_W-1:0] num;
        logic signed [DEN_OUT_W-1:0] den;
        logic                        cmp;
        logic                        dz;
    } rau_word_t;

    rau_word_t due_results[$];
    int        words_seen;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        words_seen  = 0;
    end

    function automatic logic [63:0] magnitude64(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Cross products in 64 bits, then reduce by gcd(|num|, |den|); signs kept.
    function automatic rau_word_t rational_result(op_t code, logic signed [W-1:0] an,
                                                  logic signed [W-1:0] ad,
                                                  logic signed [W-1:0] bn,
                                                  logic signed [W-1:0] bd);
        longint      x_an, x_ad, x_bn, x_bd, lhs, rhs;
        logic [63:0] n, d, g, r, t;
        rau_word_t   w;
        x_an = an;
        x_ad = ad;
        x_bn = bn;
        x_bd = bd;
        lhs  = x_an * x_bd;
        rhs  = x_ad * x_bn;
        n    = '0;
        d    = '0;
        w    = '0;
        case (code)
            OP_ADD: begin n = lhs + rhs;   d = x_ad * x_bd; end
            OP_SUB: begin n = lhs - rhs;   d = x_ad * x_bd; end
            OP_MUL: begin n = x_an * x_bn; d = x_ad * x_bd; end
            OP_DIV: begin n = lhs;         d = rhs;         end
            OP_EQ:  w.cmp = (lhs == rhs);
            OP_GT:  w.cmp = (lhs > rhs);
            OP_LT:  w.cmp = (lhs < rhs);
            OP_GE:  w.cmp = (lhs >= rhs);
            OP_LE:  w.cmp = (lhs <= rhs);
            default: ;
        endcase
        if (code <= OP_DIV) begin
            r = magnitude64(n);
            t = magnitude64(d);
            while (t != 0) begin
                g = r % t;
                r = t;
                t = g;
            end
            g = r;
            if (g == 0) begin
                // 0/0: nothing to divide by
                w.dz = 1'b1;
            end else begin
                n = n[63] ? (64'd0 - magnitude64(n) / g) : n / g;
                d = d[63] ? (64'd0 - magnitude64(d) / g) : d / g;
                w.num = n[NUM_OUT_W-1:0];
                w.den = d[DEN_OUT_W-1:0];
            end
        end
        return w;
    endfunction

    task automatic log_mismatch(string what, rau_word_t want, rau_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t word %0d %s: expected num=%0d den=%0d cmp=%0b dz=%0b, got num=%0d den=%0d cmp=%0b dz=%0b",
                     $time, words_seen, what, want.num, want.den, want.cmp, want.dz,
                     got.num, got.den, got.cmp, got.dz);
    endtask

    always @(posedge clk) begin
        rau_word_t got, want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = '{res_num, res_den, cmp_true, div_zero};
                if (due_results.size() == 0) begin
                    log_mismatch("unexpected", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want)
                        log_mismatch("mismatch", want, got);
                end
                words_seen++;
            end
            if (in_valid && !in_stall)
                due_results.push_back(rational_result(op, a_num, a_den, b_num, b_den));
            outstanding = due_results.size();
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the rational arithmetic unit: a directed pass over
// operand extremes, every opcode, zero parts and negative denominators, then
// random words under random idling and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import rau_pkg::*;

    localparam int  W          = OPERAND_WIDTH_DEF;
    localparam int  WORDS      = 1400;  // total input words
    localparam int  QUIET_MAX  = 4000;  // worst word plus stalls
    localparam int  TAIL       = 200;   // settle time after the last result
    localparam op_t OP_TOP     = op_t'((1 << OP_W) - 1);
    localparam op_t OP_UNUSED  = op_t'(OP_LE + 1);

    // operand extremes, kept as int and cut to W bits when driven
    localparam int S_MIN = -(2 ** (W - 1));
    localparam int S_MAX = (2 ** (W - 1)) - 1;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    op_t                         op = OP_ADD;
    logic signed [W-1:0]         a_num = '0;
    logic signed [W-1:0]         a_den = '0;
    logic signed [W-1:0]         b_num = '0;
    logic signed [W-1:0]         b_den = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [NUM_OUT_W-1:0] res_num;
    logic signed [DEN_OUT_W-1:0] res_den;
    logic                        cmp_true;
    logic                        div_zero;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    bit steady = 1'b0;  // set: neither side idles

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rational_arithmetic_unit #(.OPERAND_WIDTH(W)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_num   (res_num),
        .res_den   (res_den),
        .cmp_true  (cmp_true),
        .div_zero  (div_zero)
    );

    rau_checker #(.W(W)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .a_num       (a_num),
        .a_den       (a_den),
        .b_num       (b_num),
        .b_den       (b_den),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res_num     (res_num),
        .res_den     (res_den),
        .cmp_true    (cmp_true),
        .div_zero    (div_zero),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver: stalls about a quarter of the cycles, never in the steady stretch.
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 25);

    // Watchdog: any cycle without a handshake on either side counts.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    // valid is only lowered for a gap, so it is never dropped and raised at once.
    task automatic put_word(input op_t code, input int an, input int ad,
                            input int bn, input int bd);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 25)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        a_num    <= W'(an);
        a_den    <= W'(ad);
        b_num    <= W'(bn);
        b_den    <= W'(bd);
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Mix of extremes, small values (zero included) and full-range values.
    function automatic int pick_operand();
        case ($urandom_range(0, 9))
            0:       return S_MIN;
            1:       return S_MAX;
            2, 3, 4: return int'($urandom_range(0, 16)) - 8;
            default: return int'($urandom());
        endcase
    endfunction

    initial begin
        int  an, ad, bn, bd;
        int  k;
        op_t code;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- directed ---
        put_word(OP_ADD, 1, 2, 1, 3);
        put_word(OP_SUB, 1, 2, 1, 2);            // zero numerator reduces to 0/1
        put_word(OP_ADD, 0, 0, 0, 0);            // both parts zero
        put_word(OP_MUL, 0, 0, 5, 7);            // zero times anything over zero
        put_word(OP_DIV, 0, 3, 0, 5);            // 0/0 through divide
        put_word(OP_DIV, 3, 4, 0, 5);            // nonzero over zero denominator
        put_word(OP_MUL, S_MIN, S_MAX, S_MIN, S_MIN);
        put_word(OP_ADD, S_MAX, S_MAX, S_MAX, S_MAX);
        put_word(OP_ADD, S_MIN, S_MIN, S_MIN, S_MIN);
        put_word(OP_SUB, S_MIN, 1, S_MAX, -1);
        put_word(OP_ADD, S_MIN, S_MAX, S_MAX, S_MIN);
        put_word(OP_DIV, S_MIN, -1, S_MAX, S_MIN);
        put_word(OP_MUL, 6, -4, 3, 9);           // negative denominator stays
        put_word(OP_ADD, 7, 3, -2, 1);           // integer operand
        put_word(OP_DIV, -5, 1, 10, 1);
        put_word(OP_EQ, 1, 2, 2, 4);
        put_word(OP_EQ, 1, 2, -1, -2);
        put_word(OP_GT, 1, -2, 1, 3);            // sign of denominator enters compare
        put_word(OP_LT, S_MIN, S_MAX, S_MAX, S_MIN);
        put_word(OP_GE, 3, 3, 5, 5);
        put_word(OP_LE, S_MAX, 1, S_MIN, 1);
        put_word(OP_GT, 0, 0, 0, 0);
        put_word(OP_UNUSED, S_MIN, S_MAX, -1, 1);
        put_word(OP_TOP, S_MAX, S_MIN, 1, -1);

        // --- random ---
        for (int i = 0; i < WORDS - 24; i++) begin
            steady = (i >= 600 && i < 850);
            if ($urandom_range(0, 99) < 6)
                code = op_t'($urandom_range(OP_UNUSED, OP_TOP));
            else
                code = op_t'($urandom_range(OP_ADD, OP_LE));
            an = pick_operand();
            ad = pick_operand();
            if ($urandom_range(0, 7) == 0) begin
                // b as a scaled copy of a: equal fractions for the compares
                an = int'($urandom_range(0, 200)) - 100;
                ad = int'($urandom_range(0, 200)) - 100;
                k  = int'($urandom_range(1, 8)) - (($urandom_range(0, 1) == 1) ? 9 : 0);
                bn = an * k;
                bd = ad * k;
            end else begin
                bn = pick_operand();
                bd = ($urandom_range(0, 9) == 0) ? 1 : pick_operand();
            end
            put_word(code, an, ad, bn, bd);
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
